FILE: rtl/core/ffra_pkg.sv
// ----------------------------------------------------------------------------
// ffra_pkg
// Shared widths, codes and types of the first-fit range index allocator.
// ----------------------------------------------------------------------------
package ffra_pkg;

	localparam int IDX_W          = 12;   // slot index / start index
	localparam int LEN_W          = 13;   // run length, mark, free count, limit
	localparam int SUM_W          = 14;   // start + length, mark + length
	localparam int SLOT_COUNT_DEF = 4096;

	localparam logic [LEN_W-1:0] LIMIT_RST = 13'd4096;

	typedef enum logic [1:0] {
		REQ_ALLOC = 2'd0,
		REQ_FREE  = 2'd1,
		REQ_CHECK = 2'd2,
		REQ_RESET = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_NOSPACE = 3'd1,
		ST_ZERO    = 3'd2,
		ST_BEYOND  = 3'd3,
		ST_DOUBLE  = 3'd4
	} status_t;

	// bitmap port request from the sequencer
	typedef struct packed {
		logic rd;
		logic wr;
		logic wdata;
	} map_req_t;

endpackage

FILE: rtl/core/ffra_map.sv
// ----------------------------------------------------------------------------
// ffra_map
// Free-slot bitmap: one bit per slot, one access per cycle, registered read.
// ----------------------------------------------------------------------------
module ffra_map #(
	parameter int DEPTH = ffra_pkg::SLOT_COUNT_DEF,
	parameter int AW    = 12
) (
	input  logic              clk,
	input  ffra_pkg::map_req_t req,
	input  logic [AW-1:0]     addr,
	output logic              rd_data
);
	import ffra_pkg::*;

	logic mem [DEPTH];

	always_ff @(posedge clk) begin
		if (req.wr) begin
			mem[addr] <= req.wdata;
		end
		if (req.rd) begin
			rd_data <= mem[addr];
		end
	end

endmodule

FILE: rtl/core/ffra_engine.sv
// ----------------------------------------------------------------------------
// ffra_engine
// Request sequencer: decodes a request, walks the bitmap one slot per cycle
// (first-fit scan, run check, run fill, mark shrink) and holds the result.
// ----------------------------------------------------------------------------
module ffra_engine #(
	parameter int AW = 12
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  ffra_pkg::req_t              req_type,
	input  logic [ffra_pkg::IDX_W-1:0]  start_index,
	input  logic [ffra_pkg::LEN_W-1:0]  run_length,
	input  logic [ffra_pkg::LEN_W-1:0]  lim,
	output ffra_pkg::map_req_t          map_req,
	output logic [AW-1:0]               map_addr,
	input  logic                        map_rd_data,
	output logic                        done,
	output ffra_pkg::status_t           status,
	output logic [ffra_pkg::IDX_W-1:0]  slot_index,
	output logic                        run_in_use
);
	import ffra_pkg::*;

	localparam int PW = (AW > SUM_W) ? AW : SUM_W;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_DECODE = 7'b0000010,
		S_SCAN   = 7'b0000100,
		S_CHECK  = 7'b0001000,
		S_FILL   = 7'b0010000,
		S_SHRINK = 7'b0100000,
		S_DONE   = 7'b1000000
	} state_t;

	state_t             state_q;
	req_t               op_q;
	logic [IDX_W-1:0]   start_q;
	logic [LEN_W-1:0]   len_q;
	logic [LEN_W-1:0]   hw_q;
	logic [LEN_W-1:0]   ft_q;
	logic [PW-1:0]      ptr_q;
	logic [PW-1:0]      rem_q;
	logic [PW-1:0]      first_q;
	logic [LEN_W-1:0]   run_q;
	logic               hit_q;
	logic               fill_val_q;
	logic               then_shrink_q;
	status_t            status_q;
	logic [IDX_W-1:0]   slot_q;
	logic               in_use_q;
	logic               rd_vld_s1;
	logic [PW-1:0]      eidx_s1;

	logic               sweep;
	logic               issue;
	logic               bump_ok;
	logic               beyond;
	logic [PW-1:0]      run_first;

	assign sweep   = (state_q == S_SCAN) || (state_q == S_CHECK) || (state_q == S_SHRINK);
	assign issue   = sweep && (rem_q != '0);
	assign bump_ok = ({1'b0, hw_q} + {1'b0, len_q}) <= {1'b0, lim};
	assign beyond  = ({2'b00, start_q} + {1'b0, len_q}) > {1'b0, hw_q};
	// first slot of the run that the current hit extends
	assign run_first = (run_q == '0) ? eidx_s1 : first_q;

	assign map_req.rd    = issue;
	assign map_req.wr    = (state_q == S_FILL);
	assign map_req.wdata = fill_val_q;
	assign map_addr      = ptr_q[AW-1:0];

	assign busy       = (state_q != S_IDLE);
	assign done       = (state_q == S_DONE);
	assign status     = status_q;
	assign slot_index = slot_q;
	assign run_in_use = in_use_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			op_q          <= REQ_ALLOC;
			start_q       <= '0;
			len_q         <= '0;
			hw_q          <= '0;
			ft_q          <= '0;
			ptr_q         <= '0;
			rem_q         <= '0;
			first_q       <= '0;
			run_q         <= '0;
			hit_q         <= 1'b0;
			fill_val_q    <= 1'b0;
			then_shrink_q <= 1'b0;
			status_q      <= ST_OK;
			slot_q        <= '0;
			in_use_q      <= 1'b0;
			rd_vld_s1     <= 1'b0;
			eidx_s1       <= '0;
		end else begin
			rd_vld_s1 <= issue;
			if (issue) begin
				eidx_s1 <= ptr_q;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q    <= req_type;
						start_q <= start_index;
						len_q   <= run_length;
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					slot_q   <= '0;
					in_use_q <= 1'b0;
					status_q <= ST_OK;
					case (op_q)
						REQ_ALLOC: begin
							if (len_q == '0) begin
								status_q <= ST_ZERO;
								state_q  <= S_DONE;
							end else if (ft_q >= len_q) begin
								ptr_q   <= '0;
								rem_q   <= PW'(hw_q);
								run_q   <= '0;
								state_q <= S_SCAN;
							end else if (bump_ok) begin
								slot_q        <= hw_q[IDX_W-1:0];
								ptr_q         <= PW'(hw_q);
								rem_q         <= PW'(len_q);
								hw_q          <= hw_q + len_q;
								fill_val_q    <= 1'b0;
								then_shrink_q <= 1'b0;
								state_q       <= S_FILL;
							end else begin
								status_q <= ST_NOSPACE;
								state_q  <= S_DONE;
							end
						end
						REQ_FREE, REQ_CHECK: begin
							if (len_q == '0) begin
								status_q <= ST_ZERO;
								state_q  <= S_DONE;
							end else if (beyond) begin
								status_q <= ST_BEYOND;
								state_q  <= S_DONE;
							end else begin
								ptr_q   <= PW'(start_q);
								rem_q   <= PW'(len_q);
								hit_q   <= 1'b0;
								state_q <= S_CHECK;
							end
						end
						REQ_RESET: begin
							hw_q    <= '0;
							ft_q    <= '0;
							state_q <= S_DONE;
						end
						default: begin
							state_q <= S_DONE;
						end
					endcase
				end
				S_SCAN: begin
					if (issue) begin
						ptr_q <= ptr_q + 1'b1;
						rem_q <= rem_q - 1'b1;
					end
					if (rd_vld_s1) begin
						if (map_rd_data) begin
							first_q <= run_first;
							run_q   <= run_q + 1'b1;
							if ((run_q + 1'b1) == len_q) begin
								// reuse freed run: mark it in use again
								slot_q        <= run_first[IDX_W-1:0];
								ptr_q         <= run_first;
								rem_q         <= PW'(len_q);
								ft_q          <= ft_q - len_q;
								fill_val_q    <= 1'b0;
								then_shrink_q <= 1'b0;
								state_q       <= S_FILL;
							end
						end else begin
							run_q <= '0;
						end
					end else if (rem_q == '0) begin
						if (bump_ok) begin
							slot_q        <= hw_q[IDX_W-1:0];
							ptr_q         <= PW'(hw_q);
							rem_q         <= PW'(len_q);
							hw_q          <= hw_q + len_q;
							fill_val_q    <= 1'b0;
							then_shrink_q <= 1'b0;
							state_q       <= S_FILL;
						end else begin
							status_q <= ST_NOSPACE;
							state_q  <= S_DONE;
						end
					end
				end
				S_CHECK: begin
					if (issue) begin
						ptr_q <= ptr_q + 1'b1;
						rem_q <= rem_q - 1'b1;
					end
					if (rd_vld_s1 && map_rd_data) begin
						hit_q <= 1'b1;
					end
					if (!rd_vld_s1 && (rem_q == '0)) begin
						if (op_q == REQ_FREE) begin
							if (hit_q) begin
								status_q <= ST_DOUBLE;
								state_q  <= S_DONE;
							end else begin
								ptr_q         <= PW'(start_q);
								rem_q         <= PW'(len_q);
								ft_q          <= ft_q + len_q;
								fill_val_q    <= 1'b1;
								then_shrink_q <= 1'b1;
								state_q       <= S_FILL;
							end
						end else begin
							in_use_q <= !hit_q;
							state_q  <= S_DONE;
						end
					end
				end
				S_FILL: begin
					ptr_q <= ptr_q + 1'b1;
					rem_q <= rem_q - 1'b1;
					if (rem_q == PW'(1)) begin
						if (then_shrink_q) begin
							ptr_q   <= PW'(hw_q) - 1'b1;
							rem_q   <= PW'(hw_q);
							state_q <= S_SHRINK;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_SHRINK: begin
					// walk down from the mark while the top slot is free
					if (issue) begin
						ptr_q <= ptr_q - 1'b1;
						rem_q <= rem_q - 1'b1;
					end
					if (rd_vld_s1) begin
						if (map_rd_data) begin
							hw_q <= hw_q - 1'b1;
							ft_q <= ft_q - 1'b1;
						end else begin
							state_q <= S_DONE;
						end
					end else if (rem_q == '0) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_free_le_mark: assert property (@(posedge clk) disable iff (!arst_n)
		ft_q <= hw_q)
		else $error("free count above high-water mark");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted request did not start");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_fail_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != ST_OK)) |-> ((slot_index == '0) && !run_in_use))
		else $error("result fields set on failed request");

	a_write_below_mark: assert property (@(posedge clk) disable iff (!arst_n)
		map_req.wr |-> (ptr_q < PW'(hw_q)))
		else $error("bitmap write at or above high-water mark");

endmodule

FILE: rtl/core/first_fit_range_index_allocator_core.sv
// ----------------------------------------------------------------------------
// first_fit_range_index_allocator_core
// Contiguous slot-run allocator: first-fit reuse of freed slots below a
// high-water mark, else bump allocation up to a configured limit.
//
//   channel   handshake                    payload
//   -------   --------------------------   -----------------------------------
//   request   start, busy (taken !busy)    req_type, start_index, run_length
//   result    done (one-cycle strobe)      status, slot_index, run_in_use
//   config    cfg_valid, cfg_ready         cfg_data (slot_limit)
//
// One request at a time; busy is high from acceptance through the result cycle.
// Every request is decoded first; reset, zero length, beyond the mark and an
// alloc refused without a scan end there. Check and double free read the run;
// alloc by bump fills it; alloc by reuse scans below the mark, then fills the
// run; an alloc whose scan fails bumps and fills, or is refused; free reads
// the run, fills it, then walks the mark down over free top slots. All walks
// use the single bitmap port, one slot per cycle.
// No clearing pass after reset: slots are zeroed as the mark is bumped over them.
// Results cannot be stalled; cfg_ready is always high.
// ----------------------------------------------------------------------------
module first_fit_range_index_allocator_core #(
	parameter int SLOT_COUNT = ffra_pkg::SLOT_COUNT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  req_type,
	input  logic [ffra_pkg::IDX_W-1:0]  start_index,
	input  logic [ffra_pkg::LEN_W-1:0]  run_length,
	output logic                        done,
	output logic [2:0]                  status,
	output logic [ffra_pkg::IDX_W-1:0]  slot_index,
	output logic                        run_in_use,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [ffra_pkg::LEN_W-1:0]  cfg_data
);
	import ffra_pkg::*;

	localparam int AW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CMP_W = ($clog2(SLOT_COUNT + 1) > LEN_W) ? $clog2(SLOT_COUNT + 1) : LEN_W;
	localparam logic [CMP_W-1:0] SC_CMP = CMP_W'(SLOT_COUNT);

	logic [LEN_W-1:0] slot_limit_q;
	logic [LEN_W-1:0] lim;
	map_req_t         map_req;
	logic [AW-1:0]    map_addr;
	logic             map_rd_data;
	status_t          status_e;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_limit_q <= LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			slot_limit_q <= cfg_data;
		end
	end

	// a limit above the heap acts as the heap size
	assign lim = (CMP_W'(slot_limit_q) > SC_CMP) ? LEN_W'(SLOT_COUNT) : slot_limit_q;

	ffra_engine #(
		.AW (AW)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req_type    (req_t'(req_type)),
		.start_index (start_index),
		.run_length  (run_length),
		.lim         (lim),
		.map_req     (map_req),
		.map_addr    (map_addr),
		.map_rd_data (map_rd_data),
		.done        (done),
		.status      (status_e),
		.slot_index  (slot_index),
		.run_in_use  (run_in_use)
	);

	ffra_map #(
		.DEPTH (SLOT_COUNT),
		.AW    (AW)
	) u_map (
		.clk     (clk),
		.req     (map_req),
		.addr    (map_addr),
		.rd_data (map_rd_data)
	);

	assign status = status_e;

endmodule
